// ----- design/assert_macros.svh -----
// Assertion macros used by autokey_xor_stream_decrypt.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define AKXD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define AKXD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/akxd_pkg.sv -----
// Shared types and constants for the autokey XOR stream decryptor.
// No dependencies.
package akxd_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned ROT_BACK    = 31;

  localparam logic [WORD_W-1:0] KEY_WHITEN = 32'h5555_5555;
  localparam logic [WORD_W-1:0] TABLE_MULT = 32'd39916801;

  typedef enum logic [1:0] {
    FUNC_SEED      = 2'd0,
    FUNC_WORD      = 2'd1,
    FUNC_BYTE      = 2'd2,
    FUNC_WORD_PEEK = 2'd3
  } akxd_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK
  } akxd_state_e;

  typedef struct packed {
    akxd_func_e        func;
    logic [WORD_W-1:0] data_word;
  } akxd_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] plain_word;
    logic              not_seeded;
  } akxd_out_t;

endpackage

// ----- design/autokey_xor_stream_decrypt.sv -----
// Top level of the autokey XOR stream decryptor: control, running key, result buffer.
// Depends on akxd_pkg, akxd_ram and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | to block  | in_valid_i/in_ready_o  | in_req_i  (func, data_word)
//  out     | from block| out_valid_o/out_ready_i| out_rsp_o (plain_word, not_seeded)
//
// A peek needs no table lookup; a byte looks up lane 0 and a word all four lanes in turn,
// each XORed into the key. A seed is accepted and then fills the whole table. The
// single-port table RAM serves one lookup per cycle, the fill writes one entry a cycle.
// Reset clears the key, the seeded flag and the control; the table is left as is and
// its contents are only used after a seed has filled it, so there is no clearing pass.
// A stalled output holds; one more result can wait in a buffer while the next
// request is taken, after that the input stalls until the output drains.
module autokey_xor_stream_decrypt
  import akxd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  akxd_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output akxd_out_t out_rsp_o
);

`include "assert_macros.svh"

  akxd_state_e state_q, state_d;

  logic [WORD_W-1:0] key_q, key_d;     // running key
  logic [WORD_W-1:0] gen_q, gen_d;     // table generator
  logic [WORD_W-1:0] data_q, data_d;   // ciphertext of the request in lookup
  logic [TBL_AW-1:0] cnt_q, cnt_d;     // fill address
  logic [1:0]        idx_q, idx_d;     // next byte lane to look up
  logic              byte_q, byte_d;   // single-lookup request
  logic              seeded_q, seeded_d;

  akxd_out_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  akxd_out_t res_q, res_d;             // result waiting for the output register
  logic      res_pend_q, res_pend_d;

  logic              ram_we;
  logic [TBL_AW-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              in_acc;
  logic              out_free;
  logic [WORD_W-1:0] gen_rot;
  logic [WORD_W-1:0] gen_next;
  akxd_out_t         res_now;

  assign in_ready_o = (state_q == ST_IDLE) && !res_pend_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Generator step: rotate right by one, multiply mod 2^32.
  assign gen_rot  = (gen_q >> 1) | (gen_q << ROT_BACK);
  assign gen_next = gen_rot * TABLE_MULT;

  // Result is formed from the key as it stands when the request is accepted.
  always_comb begin
    res_now = '0;
    if (!seeded_q) begin
      res_now.not_seeded = 1'b1;
    end else if (in_req_i.func == FUNC_BYTE) begin
      res_now.plain_word = {{(WORD_W-8){1'b0}}, in_req_i.data_word[7:0] ^ key_q[7:0]};
    end else begin
      res_now.plain_word = in_req_i.data_word ^ key_q;
    end
  end

  // Table RAM port: fill writes, lookups read the byte lane in turn.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = gen_next;
    case (state_q)
      ST_FILL: begin
        ram_we   = 1'b1;
        ram_addr = cnt_q;
      end
      ST_LOOK: ram_addr = data_q[{idx_q, 3'b000} +: TBL_AW];
      default: ram_addr = in_req_i.data_word[TBL_AW-1:0];
    endcase
  end

  akxd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state and datapath control.
  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    gen_d    = gen_q;
    data_d   = data_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    byte_d   = byte_q;
    seeded_d = seeded_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          data_d = in_req_i.data_word;
          if (in_req_i.func == FUNC_SEED) begin
            key_d    = in_req_i.data_word ^ KEY_WHITEN;
            gen_d    = in_req_i.data_word ^ KEY_WHITEN;
            cnt_d    = '0;
            seeded_d = 1'b1;
            state_d  = ST_FILL;
          end else if (seeded_q && in_req_i.func != FUNC_WORD_PEEK) begin
            // lane 0 read is issued this cycle
            idx_d   = 2'd1;
            byte_d  = (in_req_i.func == FUNC_BYTE);
            state_d = ST_LOOK;
          end
        end
      end
      ST_FILL: begin
        gen_d = gen_next;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == TBL_AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOK: begin
        // apply the lane read last cycle, issue the next one
        key_d = key_q ^ ram_rdata;
        idx_d = idx_q + 1'b1;
        if (byte_q || idx_q == 2'd0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register plus one waiting result.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    res_pend_d  = res_pend_q;
    if (res_pend_q && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      res_pend_d  = 1'b0;
    end
    if (in_acc && in_req_i.func != FUNC_SEED) begin
      if (out_free) begin
        out_d       = res_now;
        out_valid_d = 1'b1;
      end else begin
        res_d      = res_now;
        res_pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      res_pend_q  <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      byte_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      res_pend_q  <= res_pend_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      byte_q      <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q  <= gen_d;
    data_q <= data_d;
    out_q  <= out_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A waiting result only exists while the output register is occupied.
  `AKXD_ASSERT_ALWAYS(a_pend_needs_out, res_pend_q |-> out_valid_q, "result buffer ahead of output")
  // Lookups only ever run on a filled table.
  `AKXD_ASSERT(a_look_seeded, (state_q == ST_LOOK) |-> seeded_q, "table lookup before seed")
  // The fill ends right after the last entry.
  `AKXD_ASSERT(a_fill_end, (state_q == ST_FILL && cnt_q == TBL_AW'(TABLE_DEPTH - 1)) |=> (state_q == ST_IDLE), "fill overran")
  // A word lookup walks all four lanes before returning to idle.
  `AKXD_ASSERT(a_word_lanes, (state_q == ST_LOOK && !byte_q && idx_q != 2'd0) |=> (state_q == ST_LOOK), "word lookup cut short")

endmodule

// ----- design/akxd_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Standalone; no package dependency.
module akxd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/keystream_sb_pkg.sv -----
// Scoreboard for the autokey XOR stream decryptor testbench.
// Holds its own copy of the running key and table; depends on akxd_pkg.
package keystream_sb_pkg;
  import akxd_pkg::*;

  class keystream_scoreboard;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] mix_table [TABLE_DEPTH];
    bit                seeded;
    akxd_out_t         plain_due [$];
    int unsigned       n_seed, n_word, n_byte, n_peek, n_unseeded, n_checked, n_errors;

    function new();
      key    = '0;
      seeded = 1'b0;
    endfunction

    // Appends one expected result at the tail of the queue.
    function void enqueue_due(akxd_out_t due);
      plain_due = {plain_due, due};
    endfunction

    // Called once per accepted request; queues the result each non-seed request should yield.
    function void note_request(akxd_in_t req);
      akxd_out_t         due;
      logic [WORD_W-1:0] g;
      logic [WORD_W-1:0] d;
      d              = req.data_word;
      due.plain_word = '0;
      due.not_seeded = 1'b0;
      if (req.func == FUNC_SEED) begin
        n_seed++;
        g   = d ^ KEY_WHITEN;
        key = g;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          g            = (g >> 1) | (g << ROT_BACK);
          g            = g * TABLE_MULT;
          mix_table[i] = g;
        end
        seeded = 1'b1;
        return;
      end
      if (!seeded) begin
        // key and table untouched until the first seed
        n_unseeded++;
        due.not_seeded = 1'b1;
        enqueue_due(due);
        return;
      end
      case (req.func)
        FUNC_WORD: begin
          n_word++;
          due.plain_word = d ^ key;
          key ^= mix_table[d[7:0]] ^ mix_table[d[15:8]]
               ^ mix_table[d[23:16]] ^ mix_table[d[31:24]];
        end
        FUNC_BYTE: begin
          n_byte++;
          due.plain_word = {24'b0, d[7:0] ^ key[7:0]};
          key ^= mix_table[d[7:0]];
        end
        default: begin
          n_peek++;
          due.plain_word = d ^ key;
        end
      endcase
      enqueue_due(due);
    endfunction

    // Called once per accepted result; compares against the oldest pending one.
    function void check_result(akxd_out_t got);
      akxd_out_t due;
      if (plain_due.size() == 0) begin
        n_errors++;
        $error("unexpected result: plain_word %h not_seeded %b", got.plain_word, got.not_seeded);
        return;
      end
      due = plain_due.pop_front();
      n_checked++;
      if (got.plain_word !== due.plain_word) begin
        n_errors++;
        $error("plain_word: expected %h, got %h", due.plain_word, got.plain_word);
      end
      if (got.not_seeded !== due.not_seeded) begin
        n_errors++;
        $error("not_seeded: expected %b, got %b", due.not_seeded, got.not_seeded);
      end
    endfunction

    function int unsigned pending_count();
      return plain_due.size();
    endfunction
  endclass

endpackage

// ----- test/tb_top.sv -----
// Top-level testbench for autokey_xor_stream_decrypt: directed and random requests,
// random idle on both channels, results checked by keystream_scoreboard.
// Depends on akxd_pkg, keystream_sb_pkg and the block's RTL.
module tb_top;
  import akxd_pkg::*;
  import keystream_sb_pkg::*;

  localparam int unsigned RANDOM_REQS  = 500;
  // Longest internal activity with nothing pending is a trailing seed fill of the whole table.
  localparam int unsigned DRAIN_CYCLES = 300;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  akxd_in_t  in_req    = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  akxd_out_t out_rsp_o;

  // When set, the matching side runs back to back with no idle cycles.
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  keystream_scoreboard book;

  autokey_xor_stream_decrypt DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic akxd_in_t mk_req(akxd_func_e f, logic [WORD_W-1:0] d);
    akxd_in_t r;
    r.func      = f;
    r.data_word = d;
    return r;
  endfunction

  // Seeds are rare; the bulk is word, byte and peek requests on a seeded key.
  function automatic akxd_func_e pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)  return FUNC_SEED;
    if (r < 43) return FUNC_WORD;
    if (r < 73) return FUNC_BYTE;
    return FUNC_WORD_PEEK;
  endfunction

  // Mostly uniform words, with extremes, repeated-byte words and KEY_WHITEN mixed in.
  function automatic logic [WORD_W-1:0] pick_data();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {4{b}};
      3:       return KEY_WHITEN;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request: optional idle gap, then hold valid until accepted.
  // Ready is sampled at the falling edge, where every input is settled.
  task automatic send_req(input akxd_in_t req);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    book.note_request(req);
  endtask

  // Result side: random stall before each result, checked at the falling edge
  // before the accepting rising edge.
  task automatic take_results();
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      book.check_result(out_rsp_o);
      @(posedge clk_i);
    end
  endtask

  initial begin
    book = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      take_results();
    join_none

    // Before any seed: every word, byte and peek request is flagged, result zero.
    send_req(mk_req(FUNC_WORD, 32'h1234_5678));
    send_req(mk_req(FUNC_BYTE, 32'h0000_00FF));
    send_req(mk_req(FUNC_WORD_PEEK, 32'hFFFF_FFFF));
    // Seed that whitens to zero: key and whole table zero, data passes through.
    send_req(mk_req(FUNC_SEED, KEY_WHITEN));
    send_req(mk_req(FUNC_WORD, 32'hDEAD_BEEF));
    // Seed that whitens to all ones.
    send_req(mk_req(FUNC_SEED, ~KEY_WHITEN));
    send_req(mk_req(FUNC_WORD_PEEK, 32'h0000_0000));
    send_req(mk_req(FUNC_WORD, 32'hFFFF_FFFF));
    // Byte request with junk in the upper bits, which must be ignored.
    send_req(mk_req(FUNC_BYTE, 32'hFFFF_FF00));
    send_req(mk_req(FUNC_BYTE, 32'h0000_00FF));
    // Four equal bytes: the table entries cancel, key stays put.
    send_req(mk_req(FUNC_WORD, 32'h4141_4141));
    send_req(mk_req(FUNC_WORD_PEEK, 32'hFFFF_FFFF));
    // Back-to-back reseeds fully restart key and table.
    send_req(mk_req(FUNC_SEED, 32'h0000_0000));
    send_req(mk_req(FUNC_SEED, 32'hFFFF_FFFF));
    send_req(mk_req(FUNC_WORD, 32'h0000_0000));
    send_req(mk_req(FUNC_BYTE, 32'hA5A5_A580));
    send_req(mk_req(FUNC_WORD, 32'h8000_0001));
    send_req(mk_req(FUNC_WORD_PEEK, 32'h7FFF_FFFE));
    send_req(mk_req(FUNC_BYTE, 32'h0000_0000));

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      send_req(mk_req(pick_func(), pick_data()));
    end
    in_valid <= 1'b0;

    while (book.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d seeds, %0d word, %0d byte, %0d peek and %0d unseeded requests;",
             book.n_seed, book.n_word, book.n_byte, book.n_peek, book.n_unseeded);
    $display("checked %0d results, %0d mismatches.", book.n_checked, book.n_errors);
    if (book.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/akxd_pkg.sv
design/akxd_ram.sv
design/autokey_xor_stream_decrypt.sv
test/keystream_sb_pkg.sv
test/tb_top.sv
